/* design/pwfd_pkg.sv */
// ----------------------------------------------------------------------------
// pwfd_pkg: shared types and constants of the pulse-width frame decoder
// Pulse classes, decoder modes, result layout and the CRC-16 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package pwfd_pkg;

  localparam int WIDTH_W   = 16;
  localparam int BYTE_W    = 8;
  localparam int INDEX_W   = 6;
  localparam int LEN_W     = 7;
  localparam int CRC_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_BYTES     = 64;
  localparam int DEF_MIN_CRC_INDEX = 8;

  localparam logic [WIDTH_W-1:0] RST_SHORT_MIN = 16'd50;
  localparam logic [WIDTH_W-1:0] RST_LONG_MIN  = 16'd150;
  localparam logic [WIDTH_W-1:0] RST_EXIT_MIN  = 16'd300;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  // Polynomial 0x1021 without its lowest term, which the shift brings in.
  localparam logic [CRC_W-1:0] CRC_TAPS = 16'h1020;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_MIN = 2'd0,
    CFG_LONG_MIN  = 2'd1,
    CFG_EXIT_MIN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CL_UNKNOWN = 3'd0,
    CL_SHORT   = 3'd1,
    CL_SHORT2  = 3'd2,
    CL_LONG    = 3'd3,
    CL_EXIT    = 3'd4
  } pulse_class_t;

  typedef enum logic [1:0] {
    MD_SEARCH   = 2'd0,
    MD_PREAMBLE = 2'd1,
    MD_DATA     = 2'd2,
    MD_DONE     = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] short_min;
    logic [WIDTH_W-1:0] long_min;
    logic [WIDTH_W-1:0] exit_min;
  } thresh_t;

  // What one pulse produces: an optional byte, then an optional status.
  typedef struct packed {
    logic               byte_v;
    logic               status_v;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_ok;
    logic [LEN_W-1:0]   payload_length;
    logic [CRC_W-1:0]   crc_value;
  } core_res_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic               frame_ok;
    logic [LEN_W-1:0]   payload_length;
    logic [CRC_W-1:0]   crc_value;
    logic               end_of_run;
  } out_item_t;

  // CRC-16/CCITT-FALSE over one byte, most significant bit first.
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    logic             inv;
    crc = crc_in;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      inv = data[k] ^ crc[CRC_W-1];
      crc = {crc[CRC_W-2:0], inv} ^ (inv ? CRC_TAPS : '0);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

/* design/pwfd_if.sv */
// ----------------------------------------------------------------------------
// pwfd_if: valid/ready channels of the pulse-width frame decoder
// Pulse input channel and decoded result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pwfd_in_if;
  logic                            valid;
  logic                            ready;
  logic [pwfd_pkg::WIDTH_W-1:0]    pulse_width;
  logic                            last_pulse;

  modport source (output valid, output pulse_width, output last_pulse, input ready);
  modport sink   (input valid, input pulse_width, input last_pulse, output ready);
endinterface

interface pwfd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [pwfd_pkg::BYTE_W-1:0]     byte_value;
  logic [pwfd_pkg::INDEX_W-1:0]    byte_index;
  logic                            frame_ok;
  logic [pwfd_pkg::LEN_W-1:0]      payload_length;
  logic [pwfd_pkg::CRC_W-1:0]      crc_value;
  logic                            end_of_run;

  modport source (output valid, output kind, output byte_value, output byte_index,
                  output frame_ok, output payload_length, output crc_value,
                  output end_of_run, input ready);
  modport sink   (input valid, input kind, input byte_value, input byte_index,
                  input frame_ok, input payload_length, input crc_value,
                  input end_of_run, output ready);
endinterface

`default_nettype wire

/* design/pwfd_core.sv */
// ----------------------------------------------------------------------------
// pwfd_core: pulse classifier, frame sequencer and incremental CRC search
// Updates the frame state once per fired pulse and presents its results.
// ----------------------------------------------------------------------------
`default_nettype none

module pwfd_core #(
  parameter int MAX_BYTES     = pwfd_pkg::DEF_MAX_BYTES,
  parameter int MIN_CRC_INDEX = pwfd_pkg::DEF_MIN_CRC_INDEX
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire logic [pwfd_pkg::WIDTH_W-1:0] pulse_width,
  input  wire logic                         last_pulse,
  input  wire pwfd_pkg::thresh_t            thr,
  output pwfd_pkg::core_res_t               res
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);
  localparam int unsigned MATCH_FROM = MIN_CRC_INDEX + 2;

  pwfd_pkg::mode_t          mode_r, mode_nxt;
  pwfd_pkg::pulse_class_t   prev_cls_r, prev_cls_nxt;
  pwfd_pkg::pulse_class_t   cls_raw, cls;
  logic [pwfd_pkg::BYTE_W-1:0] shift_r, shift_nxt, shift_new;
  logic [2:0]                  bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]            byte_cnt_r, byte_cnt_nxt;
  logic [pwfd_pkg::CRC_W-1:0]  crc1_r, crc1_nxt, crc2_r, crc2_nxt;
  logic [pwfd_pkg::BYTE_W-1:0] prev_byte_r, prev_byte_nxt;
  logic                        match_r, match_nxt;
  logic [pwfd_pkg::LEN_W-1:0]  match_len_r, match_len_nxt;
  logic [pwfd_pkg::CRC_W-1:0]  match_crc_r, match_crc_nxt;

  logic                        is_bit, byte_full, take, match_hit;
  logic                        end_frame, status, ok;
  logic [pwfd_pkg::LEN_W-1:0]  len_now;
  logic [pwfd_pkg::CRC_W-1:0]  crc_now;

  // A width equal to a limit falls through to unknown.
  always_comb begin
    priority if (pulse_width > thr.short_min && pulse_width < thr.long_min) begin
      cls_raw = pwfd_pkg::CL_SHORT;
    end else if (pulse_width < thr.exit_min && pulse_width > thr.long_min) begin
      cls_raw = pwfd_pkg::CL_LONG;
    end else if (pulse_width > thr.exit_min) begin
      cls_raw = pwfd_pkg::CL_EXIT;
    end else begin
      cls_raw = pwfd_pkg::CL_UNKNOWN;
    end
    cls = (cls_raw == pwfd_pkg::CL_SHORT && prev_cls_r == pwfd_pkg::CL_SHORT) ?
          pwfd_pkg::CL_SHORT2 : cls_raw;
  end

  // Mode sequencing
  always_comb begin
    mode_nxt = mode_r;
    unique case (mode_r)
      pwfd_pkg::MD_SEARCH: begin
        if (prev_cls_r == pwfd_pkg::CL_LONG && cls == pwfd_pkg::CL_LONG) begin
          mode_nxt = pwfd_pkg::MD_PREAMBLE;
        end
      end
      pwfd_pkg::MD_PREAMBLE: begin
        if (cls == pwfd_pkg::CL_SHORT2) begin
          mode_nxt = pwfd_pkg::MD_DATA;
        end
      end
      pwfd_pkg::MD_DATA: begin
        if (cls == pwfd_pkg::CL_EXIT || last_pulse) begin
          mode_nxt = pwfd_pkg::MD_DONE;
        end
      end
      pwfd_pkg::MD_DONE: begin
        mode_nxt = pwfd_pkg::MD_DONE;
      end
      default: begin
        mode_nxt = pwfd_pkg::MD_SEARCH;
      end
    endcase
    if (last_pulse) begin
      mode_nxt = pwfd_pkg::MD_SEARCH;
    end
  end

  // Bit shifting, byte capture, CRC search and results
  always_comb begin
    is_bit    = mode_r == pwfd_pkg::MD_DATA &&
                (cls == pwfd_pkg::CL_LONG || cls == pwfd_pkg::CL_SHORT2);
    shift_new = {shift_r[pwfd_pkg::BYTE_W-2:0], cls == pwfd_pkg::CL_LONG};
    byte_full = is_bit && bit_cnt_r == 3'd7;
    take      = byte_full && byte_cnt_r < CNT_MAX;
    match_hit = take && !match_r && 32'(byte_cnt_r) >= MATCH_FROM &&
                crc2_r == {prev_byte_r, shift_new};
    end_frame = mode_r == pwfd_pkg::MD_DATA &&
                (cls == pwfd_pkg::CL_EXIT || last_pulse);
    status    = end_frame || (last_pulse && mode_r != pwfd_pkg::MD_DONE);
    len_now   = match_hit ? pwfd_pkg::LEN_W'(32'(byte_cnt_r) - 32'd1) : match_len_r;
    crc_now   = match_hit ? {prev_byte_r, shift_new} : match_crc_r;
    ok        = end_frame && (match_r || match_hit);

    prev_cls_nxt  = cls;
    shift_nxt     = shift_r;
    bit_cnt_nxt   = bit_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    crc1_nxt      = crc1_r;
    crc2_nxt      = crc2_r;
    prev_byte_nxt = prev_byte_r;
    match_nxt     = match_r || match_hit;
    match_len_nxt = len_now;
    match_crc_nxt = crc_now;

    if (is_bit) begin
      shift_nxt   = byte_full ? '0 : shift_new;
      bit_cnt_nxt = bit_cnt_r + 3'd1;
    end
    if (take) begin
      byte_cnt_nxt  = byte_cnt_r + CNT_W'(1);
      crc2_nxt      = crc1_r;
      crc1_nxt      = pwfd_pkg::crc16_byte(crc1_r, shift_new);
      prev_byte_nxt = shift_new;
    end
    // Frame ends with the capture: drop everything back to the idle frame
    if (last_pulse) begin
      prev_cls_nxt  = pwfd_pkg::CL_UNKNOWN;
      shift_nxt     = '0;
      bit_cnt_nxt   = '0;
      byte_cnt_nxt  = '0;
      crc1_nxt      = pwfd_pkg::CRC_INIT;
      crc2_nxt      = pwfd_pkg::CRC_INIT;
      prev_byte_nxt = '0;
      match_nxt     = 1'b0;
      match_len_nxt = '0;
      match_crc_nxt = '0;
    end

    res.byte_v         = fire && take;
    res.status_v       = fire && status;
    res.byte_value     = shift_new;
    res.byte_index     = pwfd_pkg::INDEX_W'(byte_cnt_r);
    res.frame_ok       = ok;
    res.payload_length = ok ? len_now : '0;
    res.crc_value      = ok ? crc_now : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= pwfd_pkg::MD_SEARCH;
      prev_cls_r  <= pwfd_pkg::CL_UNKNOWN;
      shift_r     <= '0;
      bit_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      crc1_r      <= pwfd_pkg::CRC_INIT;
      crc2_r      <= pwfd_pkg::CRC_INIT;
      prev_byte_r <= '0;
      match_r     <= 1'b0;
      match_len_r <= '0;
      match_crc_r <= '0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      prev_cls_r  <= prev_cls_nxt;
      shift_r     <= shift_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      crc1_r      <= crc1_nxt;
      crc2_r      <= crc2_nxt;
      prev_byte_r <= prev_byte_nxt;
      match_r     <= match_nxt;
      match_len_r <= match_len_nxt;
      match_crc_r <= match_crc_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/pulse_width_frame_decoder_crc.sv */
// ----------------------------------------------------------------------------
// pulse_width_frame_decoder_crc: pulse-width frame decoder with CRC-16 search
// Registers each pulse, decodes it in one pass and queues its results.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   pulse_width[15:0], last_pulse
//  out_ch   out  valid/ready   kind, byte_value, byte_index, frame_ok,
//                              payload_length, crc_value, end_of_run
//  cfg_*    in   write enable  cfg_idx[1:0], cfg_wdata[15:0]
//
// One pulse a cycle while the decoder does not stall: the input register
// feeds the decoder, whose state is registered. A pulse gives up to two
// results; they enter a four-entry result queue and leave one a cycle
// while out_ch.ready is high. The decoder fires only while the queue has
// room for two results; a stalled output fills the queue and then holds
// in_ch.ready low. Synchronous reset clears the queue, the frame state and
// the limits to their defaults.
`default_nettype none

module pulse_width_frame_decoder_crc #(
  parameter int MAX_BYTES     = pwfd_pkg::DEF_MAX_BYTES,
  parameter int MIN_CRC_INDEX = pwfd_pkg::DEF_MIN_CRC_INDEX
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pwfd_in_if.sink                              in_ch,
  pwfd_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [pwfd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pwfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pwfd_pkg::thresh_t               thr_r;
  logic                            stg_v_r;
  logic [pwfd_pkg::WIDTH_W-1:0]    stg_width_r;
  logic                            stg_last_r;
  logic                            fire, pop;
  pwfd_pkg::core_res_t             res;

  pwfd_pkg::out_item_t             fifo_r [pwfd_pkg::FIFO_DEPTH];
  logic [pwfd_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [pwfd_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [pwfd_pkg::FIFO_CNT_W-1:0] npush;
  pwfd_pkg::out_item_t             byte_item, stat_item, first_item;
  pwfd_pkg::out_item_t             head;

  // Configuration limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.short_min <= pwfd_pkg::RST_SHORT_MIN;
      thr_r.long_min  <= pwfd_pkg::RST_LONG_MIN;
      thr_r.exit_min  <= pwfd_pkg::RST_EXIT_MIN;
    end else if (cfg_we) begin
      case (cfg_idx)
        pwfd_pkg::CFG_SHORT_MIN: thr_r.short_min <= cfg_wdata;
        pwfd_pkg::CFG_LONG_MIN:  thr_r.long_min  <= cfg_wdata;
        pwfd_pkg::CFG_EXIT_MIN:  thr_r.exit_min  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Input register
  assign pop          = cnt_r != '0 && out_ch.ready;
  assign fire         = stg_v_r && (cnt_r - pwfd_pkg::FIFO_CNT_W'(pop)) <=
                        pwfd_pkg::FIFO_CNT_W'(pwfd_pkg::FIFO_DEPTH - 2);
  assign in_ch.ready  = !stg_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_width_r <= in_ch.pulse_width;
      stg_last_r  <= in_ch.last_pulse;
    end
  end

  pwfd_core #(
    .MAX_BYTES     (MAX_BYTES),
    .MIN_CRC_INDEX (MIN_CRC_INDEX)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .pulse_width (stg_width_r),
    .last_pulse  (stg_last_r),
    .thr         (thr_r),
    .res         (res)
  );

  // Build the byte and status items; the byte always goes first
  always_comb begin
    byte_item.kind           = pwfd_pkg::KIND_DATA;
    byte_item.byte_value     = res.byte_value;
    byte_item.byte_index     = res.byte_index;
    byte_item.frame_ok       = 1'b0;
    byte_item.payload_length = '0;
    byte_item.crc_value      = '0;
    byte_item.end_of_run     = !res.status_v;

    stat_item.kind           = pwfd_pkg::KIND_STATUS;
    stat_item.byte_value     = '0;
    stat_item.byte_index     = '0;
    stat_item.frame_ok       = res.frame_ok;
    stat_item.payload_length = res.payload_length;
    stat_item.crc_value      = res.crc_value;
    stat_item.end_of_run     = 1'b1;

    first_item = res.byte_v ? byte_item : stat_item;
    npush      = pwfd_pkg::FIFO_CNT_W'(res.byte_v) + pwfd_pkg::FIFO_CNT_W'(res.status_v);
    cnt_nxt    = cnt_r - pwfd_pkg::FIFO_CNT_W'(pop) + npush;
  end

  always_ff @(posedge clk) begin
    if (npush != '0) begin
      fifo_r[wr_ptr_r] <= first_item;
    end
    if (res.byte_v && res.status_v) begin
      fifo_r[wr_ptr_r + pwfd_pkg::FIFO_PTR_W'(1)] <= stat_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + pwfd_pkg::FIFO_PTR_W'(npush);
      rd_ptr_r <= rd_ptr_r + pwfd_pkg::FIFO_PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  assign head                  = fifo_r[rd_ptr_r];
  assign out_ch.valid          = cnt_r != '0;
  assign out_ch.kind           = head.kind;
  assign out_ch.byte_value     = head.byte_value;
  assign out_ch.byte_index     = head.byte_index;
  assign out_ch.frame_ok       = head.frame_ok;
  assign out_ch.payload_length = head.payload_length;
  assign out_ch.crc_value      = head.crc_value;
  assign out_ch.end_of_run     = head.end_of_run;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pwfd_pkg::FIFO_CNT_W'(pwfd_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == pwfd_pkg::KIND_STATUS |-> out_ch.end_of_run)
    else $error("status result without end of run");

  a_byte_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == pwfd_pkg::KIND_DATA |->
      !out_ch.frame_ok && out_ch.payload_length == '0 && out_ch.crc_value == '0)
    else $error("data byte carries status fields");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r && !fire |=> stg_v_r && $stable(stg_width_r) && $stable(stg_last_r))
    else $error("held pulse lost while decoder stalled");

endmodule

`default_nettype wire
